### rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg: shelf placement shared definitions
// Widths, table depth, status and register codes, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Shelf table depth and derived index/count widths
  localparam int unsigned MAX_SHELVES = 256;
  localparam int unsigned SHELF_IDX_W = $clog2(MAX_SHELVES);
  localparam int unsigned SHELF_CNT_W = $clog2(MAX_SHELVES + 1);
  localparam logic [SHELF_CNT_W-1:0] COUNT_FULL = SHELF_CNT_W'(MAX_SHELVES);

  // Field widths
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HEIGHT_W = 24;
  localparam int unsigned STATUS_W = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b1;

  localparam logic [SIZE_W-1:0] STRIP_WIDTH_RST = 16'd1024;
  localparam logic              FIT_BEST        = 1'b0;
  localparam logic              FIT_NEXT        = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WIDE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic start;   // latch a new rectangle, set up the scan
    logic issue;   // read one shelf entry
    logic commit;  // place, update table, load result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic too_wide;
    logic scan_empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/shelf_fit_placement_core.sv
// ----------------------------------------------------------------------------
// shelf_fit_placement_core: shelf-based strip packing placer
// Places height-sorted rectangles onto shelves of a strip, best fit or next
// fit, and reports each position with the running packing height.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one rectangle per
//   transaction; output channel (out_valid_o/out_ready_i) returns exactly one
//   result per rectangle, in order. Configuration is written through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle.
//   One rectangle is in flight at a time. Between acceptance and a loaded
//   result it reads N shelf entries from the table, where N is:
//   every open shelf in best fit (up to 256), one in next fit, none when the
//   table is empty or the rectangle is wider than the strip.
//   The next rectangle is accepted in the cycle after the result loads.
//   The single read port of the shelf table, one entry per cycle, bounds
//   the rectangle rate.
//   A result waits in the output register while the next rectangle is being
//   scanned; if the receiver stalls, the placement of that next one holds
//   until the register frees up.
//   Reset leaves the strip width at 1024, best fit mode and an empty shelf
//   table; a rectangle flagged as job end clears the table after its result.
// ----------------------------------------------------------------------------
module shelf_fit_placement_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // rectangle input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sfp_pkg::SIZE_W-1:0]         rect_width_i,
  input  logic [sfp_pkg::SIZE_W-1:0]         rect_height_i,
  input  logic                               job_end_i,
  // placement result
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sfp_pkg::SIZE_W-1:0]         pos_x_o,
  output logic [sfp_pkg::HEIGHT_W-1:0]       pos_y_o,
  output logic [sfp_pkg::SHELF_IDX_W-1:0]    shelf_index_o,
  output logic [sfp_pkg::HEIGHT_W-1:0]       total_height_o,
  output logic [sfp_pkg::STATUS_W-1:0]       status_o,
  output logic                               job_done_o
);

  sfp_pkg::cmd_t cmd;
  sfp_pkg::sts_t sts;

  // Sequencer
  sfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Shelf table and placement arithmetic
  sfp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .job_end_i      (job_end_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .shelf_index_o  (shelf_index_o),
    .total_height_o (total_height_o),
    .status_o       (status_o),
    .job_done_o     (job_done_o)
  );

endmodule

### rtl/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl: shelf placement controller
// Sequences one rectangle: accept, width and empty-table check, shelf scan,
// drain of the last read, then commit into the result register.
// ----------------------------------------------------------------------------
module sfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfp_pkg::sts_t sts_i,
  output sfp_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o.start  = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.too_wide || sts_i.scan_empty) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // Never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("sfp_ctrl: commit while result register busy");
`endif

endmodule

### rtl/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath: shelf placement datapath
// Shelf table memories, scan comparator, placement arithmetic, config
// registers and the result register.
// ----------------------------------------------------------------------------
module sfp_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [sfp_pkg::SIZE_W-1:0]         rect_width_i,
  input  logic [sfp_pkg::SIZE_W-1:0]         rect_height_i,
  input  logic                               job_end_i,
  input  sfp_pkg::cmd_t                      cmd_i,
  output sfp_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [sfp_pkg::SIZE_W-1:0]         pos_x_o,
  output logic [sfp_pkg::HEIGHT_W-1:0]       pos_y_o,
  output logic [sfp_pkg::SHELF_IDX_W-1:0]    shelf_index_o,
  output logic [sfp_pkg::HEIGHT_W-1:0]       total_height_o,
  output logic [sfp_pkg::STATUS_W-1:0]       status_o,
  output logic                               job_done_o
);

  // Configuration
  logic [sfp_pkg::SIZE_W-1:0] strip_width_q;
  logic                       fit_mode_q;

  // Latched rectangle
  logic [sfp_pkg::SIZE_W-1:0] rw_q, rh_q;
  logic                       end_q;

  // Table bookkeeping
  logic [sfp_pkg::SHELF_CNT_W-1:0] count_q;
  logic [sfp_pkg::HEIGHT_W-1:0]    stack_q;

  // Shelf table
  logic [sfp_pkg::SIZE_W-1:0]   space_mem [sfp_pkg::MAX_SHELVES];
  logic [sfp_pkg::HEIGHT_W-1:0] base_mem  [sfp_pkg::MAX_SHELVES];

  // Scan pipeline
  logic [sfp_pkg::SHELF_IDX_W-1:0] scan_addr_q;
  logic                            rd_vld_q;
  logic [sfp_pkg::SIZE_W-1:0]      rd_space_q;
  logic [sfp_pkg::HEIGHT_W-1:0]    rd_base_q;
  logic [sfp_pkg::SHELF_IDX_W-1:0] rd_idx_q;

  // Best candidate so far
  logic                            found_q;
  logic [sfp_pkg::SIZE_W-1:0]      best_space_q;
  logic [sfp_pkg::HEIGHT_W-1:0]    best_base_q;
  logic [sfp_pkg::SHELF_IDX_W-1:0] best_idx_q;

  // Result register
  logic                            out_valid_q;
  logic [sfp_pkg::SIZE_W-1:0]      pos_x_q;
  logic [sfp_pkg::HEIGHT_W-1:0]    pos_y_q;
  logic [sfp_pkg::SHELF_IDX_W-1:0] shelf_index_q;
  logic [sfp_pkg::HEIGHT_W-1:0]    total_height_q;
  logic [sfp_pkg::STATUS_W-1:0]    status_q;
  logic                            job_done_q;

  // Combinational decision
  logic [sfp_pkg::SHELF_CNT_W-1:0] count_m1;
  logic [sfp_pkg::SHELF_IDX_W-1:0] last_idx;
  logic                            too_wide, table_full, open_new, placed, hit;
  logic [sfp_pkg::SIZE_W-1:0]      sel_space, wr_space, px;
  logic [sfp_pkg::HEIGHT_W-1:0]    sel_base, stack_next, py;
  logic [sfp_pkg::SHELF_IDX_W-1:0] sel_idx;
  logic [sfp_pkg::HEIGHT_W:0]      stack_sum;
  logic [sfp_pkg::STATUS_W-1:0]    status_d;
  logic                            mem_we;

  assign count_m1   = count_q - 1'b1;
  assign last_idx   = count_m1[sfp_pkg::SHELF_IDX_W-1:0];
  assign too_wide   = (rw_q > strip_width_q);
  assign table_full = (count_q == sfp_pkg::COUNT_FULL);
  assign open_new   = !too_wide && !found_q && !table_full;
  assign placed     = !too_wide && (found_q || !table_full);

  // Tightest fit so far; strict less-than keeps the lowest shelf on ties
  assign hit = (rd_space_q >= rw_q) && (!found_q || (rd_space_q < best_space_q));

  // Chosen shelf: the best existing one or a fresh one on top
  assign sel_space = open_new ? strip_width_q : best_space_q;
  assign sel_base  = open_new ? stack_q : best_base_q;
  assign sel_idx   = open_new ? count_q[sfp_pkg::SHELF_IDX_W-1:0] : best_idx_q;
  assign wr_space  = sel_space - rw_q;

  // Stack grows by the opener's height, saturating at the 24-bit limit
  assign stack_sum  = {1'b0, stack_q}
                    + {{(sfp_pkg::HEIGHT_W + 1 - sfp_pkg::SIZE_W){1'b0}}, rh_q};
  assign stack_next = !open_new ? stack_q :
                      (stack_sum[sfp_pkg::HEIGHT_W] ? {sfp_pkg::HEIGHT_W{1'b1}}
                                                    : stack_sum[sfp_pkg::HEIGHT_W-1:0]);

  assign px = placed ? (strip_width_q - sel_space) : '0;
  assign py = placed ? sel_base : '0;

  always_comb begin
    if (too_wide) begin
      status_d = sfp_pkg::STATUS_WIDE;
    end else if (!placed) begin
      status_d = sfp_pkg::STATUS_FULL;
    end else begin
      status_d = sfp_pkg::STATUS_PLACED;
    end
  end

  assign mem_we = cmd_i.commit && placed;

  // Status to the controller
  assign sts_o.too_wide   = too_wide;
  assign sts_o.scan_empty = (count_q == '0);
  assign sts_o.scan_last  = (scan_addr_q == last_idx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_width_q <= sfp_pkg::STRIP_WIDTH_RST;
      fit_mode_q    <= sfp_pkg::FIT_BEST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfp_pkg::CFG_STRIP_WIDTH: strip_width_q <= cfg_wdata_i;
        sfp_pkg::CFG_FIT_MODE:    fit_mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Rectangle capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rw_q  <= rect_width_i;
      rh_q  <= rect_height_i;
      end_q <= job_end_i;
    end
  end

  // Shelf table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      space_mem[sel_idx] <= wr_space;
      base_mem[sel_idx]  <= sel_base;
    end
    if (cmd_i.issue) begin
      rd_space_q <= space_mem[scan_addr_q];
      rd_base_q  <= base_mem[scan_addr_q];
      rd_idx_q   <= scan_addr_q;
    end
  end

  // Scan address and candidate tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        // next fit looks at the newest shelf only
        scan_addr_q <= (fit_mode_q == sfp_pkg::FIT_NEXT) ? last_idx : '0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
        if (rd_vld_q && hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && hit) begin
      best_space_q <= rd_space_q;
      best_base_q  <= rd_base_q;
      best_idx_q   <= rd_idx_q;
    end
  end

  // Shelf count and stack height; end of job clears both
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      stack_q <= '0;
    end else if (cmd_i.commit) begin
      if (end_q) begin
        count_q <= '0;
        stack_q <= '0;
      end else begin
        count_q <= count_q + {{(sfp_pkg::SHELF_CNT_W - 1){1'b0}}, open_new};
        stack_q <= stack_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pos_x_q        <= px;
      pos_y_q        <= py;
      shelf_index_q  <= placed ? sel_idx : '0;
      total_height_q <= stack_next;
      status_q       <= status_d;
      job_done_q     <= end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign shelf_index_o  = shelf_index_q;
  assign total_height_o = total_height_q;
  assign status_o       = status_q;
  assign job_done_o     = job_done_q;

`ifndef ASSERT_OFF
  // Shelf count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sfp_pkg::COUNT_FULL)
    else $error("sfp_datapath: shelf count overflow");

  // Only open shelves are ever compared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ({1'b0, rd_idx_q} < count_q))
    else $error("sfp_datapath: scan read beyond open shelves");

  // Last rectangle of a job leaves an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && end_q) |=> (count_q == '0) && (stack_q == '0))
    else $error("sfp_datapath: table not cleared at end of job");
`endif

endmodule
